// File: sv/dmm_pkg.sv
// ----------------------------------------------------------------------------
// dmm_pkg
// Types, constants and helpers shared by the dense matrix multiply block.
// ----------------------------------------------------------------------------
package dmm_pkg;

    localparam int ELEM_W = 16;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W  = 35;
    localparam int IDX_W  = 3;
    localparam int DIM_W  = 4;
    localparam int CFG_AW = 2;

    typedef logic [DIM_W-1:0]  dim_t;
    typedef logic [CFG_AW-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_ROWS_A     = 2'd0;
    localparam cfg_addr_t REG_INNER_SIZE = 2'd1;
    localparam cfg_addr_t REG_COLS_B     = 2'd2;

    localparam dim_t DIM_RESET = 4'd8;

    // One element of A moving down the cell chain
    typedef struct packed {
        logic                     valid;
        logic                     first;
        logic                     last;
        logic [IDX_W-1:0]         k;
        logic signed [ELEM_W-1:0] a;
    } a_flit_t;

    // Zero counts as one, anything above the limit is clamped
    function automatic dim_t eff_dim(input dim_t value, input dim_t max_dim);
        dim_t res;
        if (value == '0)
        begin
            res = dim_t'(1);
        end
        else if (value > max_dim)
        begin
            res = max_dim;
        end
        else
        begin
            res = value;
        end
        return res;
    endfunction

endpackage

// File: sv/dmm_ram.sv
// ----------------------------------------------------------------------------
// dmm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/dmm_cell.sv
// ----------------------------------------------------------------------------
// dmm_cell
// One column cell: holds a column of B, multiplies each passing A element by
// the matching B entry and accumulates one C element. Accumulators also form
// a shift chain for unloading results.
// ----------------------------------------------------------------------------
module dmm_cell #(
    parameter int MAX_DIM = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dmm_pkg::a_flit_t                 flit_in,
    output dmm_pkg::a_flit_t                 flit_out,
    input  logic                             b_we,
    input  logic [dmm_pkg::IDX_W-1:0]        b_addr,
    input  logic signed [dmm_pkg::ELEM_W-1:0] b_data,
    input  logic                             shift_en,
    input  logic signed [dmm_pkg::ACC_W-1:0] acc_in,
    output logic signed [dmm_pkg::ACC_W-1:0] acc_out
);

    localparam int B_AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic                               s1_valid_reg;
    logic                               s1_first_reg;
    logic                               s1_last_reg;
    logic [dmm_pkg::IDX_W-1:0]          s1_k_reg;
    logic signed [dmm_pkg::ELEM_W-1:0]  s1_a_reg;
    logic                               s2_valid_reg;
    logic                               s2_first_reg;
    logic signed [dmm_pkg::ELEM_W-1:0]  b_rdata;
    logic signed [dmm_pkg::PROD_W-1:0]  prod_reg;
    logic signed [dmm_pkg::PROD_W-1:0]  prod_next;
    logic signed [dmm_pkg::ACC_W-1:0]   acc_reg;
    logic signed [dmm_pkg::ACC_W-1:0]   prod_ext;

    // B entry is read as the element enters, so it lines up with stage 1
    dmm_ram #(
        .WIDTH (dmm_pkg::ELEM_W),
        .DEPTH (MAX_DIM),
        .AW    (B_AW)
    ) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_addr[B_AW-1:0]),
        .wdata (b_data),
        .raddr (flit_in.k[B_AW-1:0]),
        .rdata (b_rdata)
    );

    assign prod_next = s1_a_reg * b_rdata;
    assign prod_ext  = {{(dmm_pkg::ACC_W - dmm_pkg::PROD_W){prod_reg[dmm_pkg::PROD_W-1]}},
                        prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= flit_in.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= flit_in.first;
        s1_last_reg  <= flit_in.last;
        s1_k_reg     <= flit_in.k;
        s1_a_reg     <= flit_in.a;
        s2_first_reg <= s1_first_reg;
        prod_reg     <= prod_next;
        if (s2_valid_reg)
        begin
            acc_reg <= s2_first_reg ? prod_ext : acc_reg + prod_ext;
        end
        else if (shift_en)
        begin
            acc_reg <= acc_in;
        end
    end

    assign flit_out = {s1_valid_reg, s1_first_reg, s1_last_reg, s1_k_reg, s1_a_reg};
    assign acc_out  = acc_reg;

endmodule

// File: sv/dense_matrix_multiply.sv
// ----------------------------------------------------------------------------
// dense_matrix_multiply
// C = A * B on signed Q8.8 matrices with exact results, 16 fraction bits.
// ----------------------------------------------------------------------------
// Elements of A (row-major) then B (row-major) are taken one per cycle; A is
// kept in a RAM, each column of B in its own cell of a chain of MAX_DIM
// multiply-accumulate cells. After the last element of B the block computes
// C one row at a time: the row of A streams through the chain, one element
// per cycle, then the row's results are shifted out of cell 0 in column
// order, one per transfer. Input is not taken while C is being produced.
// A full pass loads all of A and B, then per row streams the row through the
// cell chain and sends its cols results; the chain latency and the single
// result port bound the time that each row takes.
// Writing any of the three configuration registers restarts the load.
module dense_matrix_multiply #(
    parameter int MAX_DIM = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_we,
    input  logic [dmm_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [dmm_pkg::DIM_W-1:0]  cfg_wdata,
    // input elements
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [15:0]                s_axis_tdata,  // [15:0] element
    // result elements
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [47:0]                m_axis_tdata,  // [34:0] product_element,
                                                      // [37:35] row_index,
                                                      // [40:38] col_index
    output logic                       m_axis_tlast
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(2 * DEPTH + 1);
    localparam int TOT_W  = 2 * dmm_pkg::DIM_W + 1;
    localparam int IDX_W  = dmm_pkg::IDX_W;
    localparam dmm_pkg::dim_t MAX_D = dmm_pkg::DIM_W'(MAX_DIM);

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    dmm_pkg::dim_t       rows_reg, rows_next;
    dmm_pkg::dim_t       inner_reg, inner_next;
    dmm_pkg::dim_t       cols_reg, cols_next;
    logic [CNT_W-1:0]    lc_reg, lc_next;
    logic [IDX_W-1:0]    bk_reg, bk_next;
    logic [IDX_W-1:0]    bc_reg, bc_next;
    logic [ADDR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    logic [IDX_W-1:0]    row_reg, row_next;
    logic [IDX_W-1:0]    col_reg, col_next;
    logic                iss_valid_reg, iss_valid_next;
    logic                iss_first_reg, iss_first_next;
    logic                iss_last_reg, iss_last_next;
    logic [IDX_W-1:0]    iss_k_reg, iss_k_next;
    logic                tail_d1_reg, tail_d2_reg;

    dmm_pkg::dim_t       nr, nk, nc;
    logic [TOT_W-1:0]    a_total, total;
    logic [CNT_W-1:0]    lc_eff;
    logic                in_xfer, out_xfer, is_a, load_done, cfg_hit;
    logic                k_end, row_end, col_end;
    logic [ADDR_W-1:0]   a_waddr;
    logic [dmm_pkg::ELEM_W-1:0] a_rdata;
    logic signed [dmm_pkg::ELEM_W-1:0] elem;

    dmm_pkg::a_flit_t                  chain [0:MAX_DIM];
    logic signed [dmm_pkg::ACC_W-1:0]  acc   [0:MAX_DIM];

    assign nr = dmm_pkg::eff_dim(rows_reg, MAX_D);
    assign nk = dmm_pkg::eff_dim(inner_reg, MAX_D);
    assign nc = dmm_pkg::eff_dim(cols_reg, MAX_D);

    assign a_total = TOT_W'(nr) * TOT_W'(nk);
    assign total   = a_total + TOT_W'(nk) * TOT_W'(nc);

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign in_xfer  = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = (state_reg == ST_DRAIN);
    assign out_xfer = m_axis_tvalid & m_axis_tready;

    assign elem      = s_axis_tdata;
    assign lc_eff    = (TOT_W'(lc_reg) >= total) ? '0 : lc_reg;
    assign is_a      = TOT_W'(lc_eff) < a_total;
    assign load_done = (TOT_W'(lc_eff) + TOT_W'(1)) == total;
    assign a_waddr   = lc_eff[ADDR_W-1:0];
    assign cfg_hit   = cfg_we & ((cfg_addr == dmm_pkg::REG_ROWS_A) ||
                                 (cfg_addr == dmm_pkg::REG_INNER_SIZE) ||
                                 (cfg_addr == dmm_pkg::REG_COLS_B));

    assign k_end   = dmm_pkg::DIM_W'(k_reg)   == nk - dmm_pkg::DIM_W'(1);
    assign row_end = dmm_pkg::DIM_W'(row_reg) == nr - dmm_pkg::DIM_W'(1);
    assign col_end = dmm_pkg::DIM_W'(col_reg) == nc - dmm_pkg::DIM_W'(1);

    dmm_ram #(
        .WIDTH (dmm_pkg::ELEM_W),
        .DEPTH (DEPTH),
        .AW    (ADDR_W)
    ) u_a_ram (
        .clk   (clk),
        .we    (in_xfer & is_a),
        .waddr (a_waddr),
        .wdata (s_axis_tdata),
        .raddr (rd_ptr_reg),
        .rdata (a_rdata)
    );

    assign chain[0].valid = iss_valid_reg;
    assign chain[0].first = iss_first_reg;
    assign chain[0].last  = iss_last_reg;
    assign chain[0].k     = iss_k_reg;
    assign chain[0].a     = a_rdata;
    assign acc[MAX_DIM]   = '0;

    for (genvar i = 0; i < MAX_DIM; i++)
    begin : g_cell
        dmm_cell #(
            .MAX_DIM (MAX_DIM)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .flit_in  (chain[i]),
            .flit_out (chain[i+1]),
            .b_we     (in_xfer & ~is_a & (bc_reg == IDX_W'(i))),
            .b_addr   (bk_reg),
            .b_data   (elem),
            .shift_en (out_xfer),
            .acc_in   (acc[i+1]),
            .acc_out  (acc[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        rows_next      = rows_reg;
        inner_next     = inner_reg;
        cols_next      = cols_reg;
        lc_next        = lc_reg;
        bk_next        = bk_reg;
        bc_next        = bc_reg;
        rd_ptr_next    = rd_ptr_reg;
        k_next         = k_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        iss_valid_next = 1'b0;
        iss_first_next = iss_first_reg;
        iss_last_next  = iss_last_reg;
        iss_k_next     = iss_k_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (load_done)
                    begin
                        lc_next     = '0;
                        bk_next     = '0;
                        bc_next     = '0;
                        rd_ptr_next = '0;
                        k_next      = '0;
                        row_next    = '0;
                        state_next  = ST_ISSUE;
                    end
                    else
                    begin
                        lc_next = lc_eff + CNT_W'(1);
                        if (!is_a)
                        begin
                            if (dmm_pkg::DIM_W'(bc_reg) == nc - dmm_pkg::DIM_W'(1))
                            begin
                                bc_next = '0;
                                bk_next = bk_reg + IDX_W'(1);
                            end
                            else
                            begin
                                bc_next = bc_reg + IDX_W'(1);
                            end
                        end
                    end
                end
            end
            ST_ISSUE:
            begin
                iss_valid_next = 1'b1;
                iss_first_next = (k_reg == '0);
                iss_last_next  = k_end;
                iss_k_next     = k_reg;
                rd_ptr_next    = rd_ptr_reg + ADDR_W'(1);
                if (k_end)
                begin
                    k_next     = '0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_WAIT:
            begin
                if (tail_d2_reg)
                begin
                    col_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_xfer)
                begin
                    if (col_end)
                    begin
                        col_next = '0;
                        if (row_end)
                        begin
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            row_next   = row_reg + IDX_W'(1);
                            state_next = ST_ISSUE;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        if (cfg_hit)
        begin
            lc_next = '0;
            bk_next = '0;
            bc_next = '0;
            case (cfg_addr)
                dmm_pkg::REG_ROWS_A:     rows_next  = cfg_wdata;
                dmm_pkg::REG_INNER_SIZE: inner_next = cfg_wdata;
                dmm_pkg::REG_COLS_B:     cols_next  = cfg_wdata;
                default:                 rows_next  = rows_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            rows_reg      <= dmm_pkg::DIM_RESET;
            inner_reg     <= dmm_pkg::DIM_RESET;
            cols_reg      <= dmm_pkg::DIM_RESET;
            lc_reg        <= '0;
            bk_reg        <= '0;
            bc_reg        <= '0;
            rd_ptr_reg    <= '0;
            k_reg         <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            iss_valid_reg <= 1'b0;
            tail_d1_reg   <= 1'b0;
            tail_d2_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_reg      <= rows_next;
            inner_reg     <= inner_next;
            cols_reg      <= cols_next;
            lc_reg        <= lc_next;
            bk_reg        <= bk_next;
            bc_reg        <= bc_next;
            rd_ptr_reg    <= rd_ptr_next;
            k_reg         <= k_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            iss_valid_reg <= iss_valid_next;
            tail_d1_reg   <= chain[MAX_DIM].valid & chain[MAX_DIM].last;
            tail_d2_reg   <= tail_d1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_first_reg <= iss_first_next;
        iss_last_reg  <= iss_last_next;
        iss_k_reg     <= iss_k_next;
    end

    assign m_axis_tdata = {7'b0, col_reg, row_reg, acc[0]};
    assign m_axis_tlast = row_end & col_end;

endmodule

// File: bench/dense_matrix_multiply_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dense_matrix_multiply_tb
// Streams A and B elements into the matrix multiply block, predicts every C
// element in software and compares each result transfer field by field.
// A short directed plan covers extreme values, clamped dimensions, ignored
// register writes and load restarts; random passes of mixed sizes follow,
// under changing idle and stall patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module dense_matrix_multiply_tb;

    localparam int                 MAX_DIM      = 8;
    localparam int                 STORE_DEPTH  = MAX_DIM * MAX_DIM;
    localparam int                 QUIET_CYCLES = 48;
    localparam int                 HOLD_CYCLES  = 300;
    localparam int                 RANDOM_ITEMS = 440;
    localparam dmm_pkg::cfg_addr_t REG_UNUSED   = 2'd3;

    typedef struct {
        logic [dmm_pkg::ACC_W-1:0] value;
        logic [dmm_pkg::IDX_W-1:0] row;
        logic [dmm_pkg::IDX_W-1:0] col;
        logic                      last;
    } product_t;

    typedef enum logic {ROW_CFG, ROW_ELEM} row_kind_t;

    typedef struct {
        row_kind_t                        kind;
        dmm_pkg::cfg_addr_t               idx;
        logic [dmm_pkg::ELEM_W-1:0]       data;
        int                               count;
        logic                             typed;
        logic signed [dmm_pkg::ACC_W-1:0] typed_value;
    } stim_row_t;

    localparam int PLAN_LEN = 23;

    stim_row_t directed_plan [PLAN_LEN] = '{
        '{ROW_CFG,  dmm_pkg::REG_ROWS_A,     16'h0000,  1, 1'b0, 35'sd0},
        '{ROW_CFG,  dmm_pkg::REG_COLS_B,     16'h0000,  1, 1'b0, 35'sd0},
        // 1 x 8 x 1 with inner size left at reset, all most-negative
        '{ROW_ELEM, dmm_pkg::REG_ROWS_A,     16'h8000, 15, 1'b0, 35'sd0},
        '{ROW_ELEM, dmm_pkg::REG_ROWS_A,     16'h8000,  1, 1'b1, 35'sh2_0000_0000},
        '{ROW_CFG,  dmm_pkg::REG_INNER_SIZE, 16'h0001,  1, 1'b0, 35'sd0},
        '{ROW_CFG,  dmm_pkg::REG_COLS_B,     16'h000F,  1, 1'b0, 35'sd0},
        '{ROW_ELEM, dmm_pkg::REG_ROWS_A,     16'h7FFF,  1, 1'b0, 35'sd0},
        // out-of-list index mid-load, must not restart
        '{ROW_CFG,  REG_UNUSED,              16'h0005,  1, 1'b0, 35'sd0},
        '{ROW_ELEM, dmm_pkg::REG_ROWS_A,     16'h8000,  1, 1'b0, 35'sd0},
        '{ROW_ELEM, dmm_pkg::REG_ROWS_A,     16'h7FFF,  1, 1'b0, 35'sd0},
        '{ROW_ELEM, dmm_pkg::REG_ROWS_A,     16'h0000,  1, 1'b0, 35'sd0},
        '{ROW_ELEM, dmm_pkg::REG_ROWS_A,     16'hFFFF,  1, 1'b0, 35'sd0},
        '{ROW_ELEM, dmm_pkg::REG_ROWS_A,     16'h0001,  1, 1'b0, 35'sd0},
        '{ROW_ELEM, dmm_pkg::REG_ROWS_A,     16'h00FF,  1, 1'b0, 35'sd0},
        '{ROW_ELEM, dmm_pkg::REG_ROWS_A,     16'hFF00,  1, 1'b0, 35'sd0},
        '{ROW_ELEM, dmm_pkg::REG_ROWS_A,     16'h8000,  1, 1'b0, 35'sd0},
        '{ROW_CFG,  dmm_pkg::REG_COLS_B,     16'h0001,  1, 1'b0, 35'sd0},
        '{ROW_ELEM, dmm_pkg::REG_ROWS_A,     16'h7FFF,  1, 1'b0, 35'sd0},
        '{ROW_ELEM, dmm_pkg::REG_ROWS_A,     16'h8000,  1, 1'b1, -35'sd1073709056},
        // partial load dropped by a register write
        '{ROW_ELEM, dmm_pkg::REG_ROWS_A,     16'h1234,  1, 1'b0, 35'sd0},
        '{ROW_CFG,  dmm_pkg::REG_ROWS_A,     16'h0001,  1, 1'b0, 35'sd0},
        '{ROW_ELEM, dmm_pkg::REG_ROWS_A,     16'hFFFF,  1, 1'b0, 35'sd0},
        '{ROW_ELEM, dmm_pkg::REG_ROWS_A,     16'h0001,  1, 1'b1, -35'sd1}
    };

    int src_idle_pct [4] = '{0, 54, 0, 38};
    int snk_stall_pct [4] = '{0, 0, 54, 38};

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_we        = 1'b0;
    dmm_pkg::cfg_addr_t  cfg_addr      = '0;
    dmm_pkg::dim_t       cfg_wdata     = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata  = '0;    // [15:0] element
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [47:0]         m_axis_tdata;          // [34:0] product_element,
                                                // [37:35] row_index,
                                                // [40:38] col_index
    logic                m_axis_tlast;

    // predictor state
    logic signed [dmm_pkg::ELEM_W-1:0] a_mem [STORE_DEPTH];
    logic signed [dmm_pkg::ELEM_W-1:0] b_mem [STORE_DEPTH];
    int unsigned                       fill_count = 0;
    dmm_pkg::dim_t                     reg_rows   = dmm_pkg::DIM_RESET;
    dmm_pkg::dim_t                     reg_inner  = dmm_pkg::DIM_RESET;
    dmm_pkg::dim_t                     reg_cols   = dmm_pkg::DIM_RESET;
    product_t                          pending_products [$];

    int       src_idle   = 0;
    int       snk_stall  = 0;
    int       hold_req   = 0;
    int       hold_ack   = 0;
    int       hold_left  = 0;
    int       mismatch_count = 0;
    product_t mon_want;

    dense_matrix_multiply #(
        .MAX_DIM (MAX_DIM)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned used_dim(input dmm_pkg::dim_t value);
        int unsigned d;
        d = 32'(value);
        if (d == 0)
        begin
            d = 1;
        end
        if (d > MAX_DIM)
        begin
            d = MAX_DIM;
        end
        return d;
    endfunction

    function automatic int unsigned pass_length();
        int unsigned nk;
        nk = used_dim(reg_inner);
        return used_dim(reg_rows) * nk + nk * used_dim(reg_cols);
    endfunction

    // Stores one element; on the last element of B returns all of C
    function automatic void load_element(input logic [dmm_pkg::ELEM_W-1:0] value,
                                         ref product_t products [$]);
        int unsigned nr, nk, nc, a_total, total;
        longint      acc;
        product_t    p;
        nr      = used_dim(reg_rows);
        nk      = used_dim(reg_inner);
        nc      = used_dim(reg_cols);
        a_total = nr * nk;
        total   = a_total + nk * nc;
        if (fill_count >= total)
        begin
            fill_count = 0;
        end
        if (fill_count < a_total)
        begin
            a_mem[fill_count % STORE_DEPTH] = value;
        end
        else
        begin
            b_mem[(fill_count - a_total) % STORE_DEPTH] = value;
        end
        fill_count++;
        if (fill_count < total)
        begin
            return;
        end
        fill_count = 0;
        for (int unsigned r = 0; r < nr; r++)
        begin
            for (int unsigned c = 0; c < nc; c++)
            begin
                acc = 0;
                for (int unsigned k = 0; k < nk; k++)
                begin
                    acc += longint'(a_mem[(r * nk + k) % STORE_DEPTH])
                         * longint'(b_mem[(k * nc + c) % STORE_DEPTH]);
                end
                p.value = acc[dmm_pkg::ACC_W-1:0];
                p.row   = r[dmm_pkg::IDX_W-1:0];
                p.col   = c[dmm_pkg::IDX_W-1:0];
                p.last  = (r + 1 == nr) && (c + 1 == nc);
                products.push_back(p);
            end
        end
    endfunction

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_products.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input dmm_pkg::cfg_addr_t idx, input dmm_pkg::dim_t value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            dmm_pkg::REG_ROWS_A:     reg_rows  = value;
            dmm_pkg::REG_INNER_SIZE: reg_inner = value;
            dmm_pkg::REG_COLS_B:     reg_cols  = value;
            default:                 return;
        endcase
        fill_count = 0;
    endtask

    task automatic send_element(input logic [dmm_pkg::ELEM_W-1:0] value, input logic typed,
                                input logic [dmm_pkg::ACC_W-1:0] typed_value);
        product_t products [$];
        product_t p;
        while ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        load_element(value, products);
        if (typed)
        begin
            p.value  = typed_value;
            p.row    = '0;
            p.col    = '0;
            p.last   = 1'b1;
            products = '{p};
        end
        foreach (products[i])
        begin
            pending_products.push_back(products[i]);
        end
    endtask

    function automatic dmm_pkg::dim_t pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 8)
        begin
            return '0;
        end
        else if (r < 14)
        begin
            return dmm_pkg::dim_t'($urandom_range(15, 9));
        end
        else if (r < 22)
        begin
            return dmm_pkg::dim_t'(MAX_DIM);
        end
        return dmm_pkg::dim_t'($urandom_range(4, 1));
    endfunction

    function automatic logic [dmm_pkg::ELEM_W-1:0] pick_element();
        int r;
        r = $urandom_range(99);
        if (r < 10)
        begin
            return 16'h8000;
        end
        else if (r < 20)
        begin
            return 16'h7FFF;
        end
        else if (r < 25)
        begin
            return 16'h0000;
        end
        else if (r < 30)
        begin
            return 16'hFFFF;
        end
        return dmm_pkg::ELEM_W'($urandom);
    endfunction

    // result sink: random stalls plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack      <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= snk_stall);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_products.size() == 0)
            begin
                $error("result transfer with nothing expected, tdata %h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                mon_want = pending_products.pop_front();
                if (m_axis_tdata[34:0] !== mon_want.value)
                begin
                    $error("product_element: expected %h, actual %h",
                           mon_want.value, m_axis_tdata[34:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[37:35] !== mon_want.row)
                begin
                    $error("row_index: expected %0d, actual %0d",
                           mon_want.row, m_axis_tdata[37:35]);
                    mismatch_count++;
                end
                if (m_axis_tdata[40:38] !== mon_want.col)
                begin
                    $error("col_index: expected %0d, actual %0d",
                           mon_want.col, m_axis_tdata[40:38]);
                    mismatch_count++;
                end
                if (m_axis_tlast !== mon_want.last)
                begin
                    $error("last: expected %b, actual %b", mon_want.last, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int unsigned rand_items;
        int unsigned phase;
        int unsigned passes;
        int unsigned len;
        int          noise_at;
        int          mode;
        logic        broken;

        rand_items = 0;
        phase      = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == ROW_CFG)
            begin
                write_reg(directed_plan[i].idx,
                          directed_plan[i].data[dmm_pkg::DIM_W-1:0]);
            end
            else
            begin
                for (int n = 0; n < directed_plan[i].count; n++)
                begin
                    send_element(directed_plan[i].data,
                                 directed_plan[i].typed && (n == directed_plan[i].count - 1),
                                 directed_plan[i].typed_value);
                end
            end
        end

        while (rand_items < RANDOM_ITEMS)
        begin
            mode      = phase % 4;
            src_idle  = src_idle_pct[mode];
            snk_stall = snk_stall_pct[mode];
            if (phase == 0)
            begin
                // back-pressure: output held off while input keeps coming
                src_idle  = 0;
                snk_stall = 0;
                write_reg(dmm_pkg::REG_ROWS_A, 4'd2);
                write_reg(dmm_pkg::REG_INNER_SIZE, 4'd2);
                write_reg(dmm_pkg::REG_COLS_B, 4'd2);
                hold_req <= hold_req + 1;
                passes = 4;
            end
            else
            begin
                write_reg(dmm_pkg::REG_ROWS_A, pick_dim());
                write_reg(dmm_pkg::REG_INNER_SIZE, pick_dim());
                write_reg(dmm_pkg::REG_COLS_B, pick_dim());
                passes = $urandom_range(3, 1);
            end
            for (int unsigned p = 0; (p < passes) && (rand_items < RANDOM_ITEMS); p++)
            begin
                len      = pass_length();
                noise_at = ($urandom_range(7) == 0) ? int'($urandom_range(len - 1)) : -1;
                broken   = (p + 1 == passes) && (len > 1) && ($urandom_range(6) == 0);
                if (broken)
                begin
                    len = $urandom_range(len - 1, 1);
                end
                for (int unsigned e = 0; (e < len) && (rand_items < RANDOM_ITEMS); e++)
                begin
                    if (int'(e) == noise_at)
                    begin
                        write_reg(REG_UNUSED, dmm_pkg::dim_t'($urandom));
                    end
                    send_element(pick_element(), 1'b0, '0);
                    rand_items++;
                end
            end
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: dense_matrix_multiply.f
sv/dmm_pkg.sv
sv/dmm_ram.sv
sv/dmm_cell.sv
sv/dense_matrix_multiply.sv
bench/dense_matrix_multiply_tb.sv
